FILE: rtl/core/srr_pkg.sv
// srr_pkg: shared constants, types and slot arithmetic for the
// selective-repeat receiver. No dependencies; used by every rtl/core module.
package srr_pkg;

  localparam int WINDOW_MAX     = 8;
  localparam int PAYLOAD_BITS   = 64;
  localparam int SEQ_BITS       = 16;
  localparam int SLOT_BITS      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_BITS       = $clog2(WINDOW_MAX + 1);
  localparam int SUM_BITS       = CNT_BITS + 1;
  localparam int WSIZE_BITS     = 4;
  localparam int SBITS_BITS     = 5;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 5;
  localparam int CMD_DEPTH      = 2;
  localparam int CMD_PTR_BITS   = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_BITS   = $clog2(CMD_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SIZE = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEQ_BITS    = 4'd1;

  localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 4'd4;
  localparam logic [SBITS_BITS-1:0] SBITS_RESET = 5'd3;

  // result kinds
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  // work handed from the classifier to the result sequencer
  typedef struct packed {
    logic                    deliver;
    logic [SEQ_BITS-1:0]     seq;
    logic [SEQ_BITS-1:0]     mmask;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    wr_slot;
    logic [SLOT_BITS-1:0]    slot;
    logic [CNT_BITS-1:0]     count;
  } srr_cmd_t;

  // circular slot index: base + off modulo WINDOW_MAX, off at most WINDOW_MAX
  function automatic logic [SLOT_BITS-1:0] slot_add(input logic [SLOT_BITS-1:0] base,
                                                    input logic [CNT_BITS-1:0] off);
    logic [SUM_BITS-1:0] s;
    s = SUM_BITS'(base) + SUM_BITS'(off);
    if (s >= SUM_BITS'(WINDOW_MAX)) s = s - SUM_BITS'(WINDOW_MAX);
    return SLOT_BITS'(s);
  endfunction

endpackage

FILE: rtl/core/srr_front.sv
// srr_front: configuration registers, window base and slot valid marks;
// classifies each packet and queues a command. Depends on srr_pkg.
module srr_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [srr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [srr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               push,
  output logic                               full,
  input  logic [srr_pkg::SEQ_BITS-1:0]       seq_num,
  input  logic                               checksum_ok,
  input  logic [srr_pkg::PAYLOAD_BITS-1:0]   payload,
  output srr_pkg::srr_cmd_t                  cmd,
  output logic                               cmd_push,
  input  logic                               cmd_full
);
  import srr_pkg::*;

  logic [WSIZE_BITS-1:0] window_size;
  logic [SBITS_BITS-1:0] seq_bits;
  logic [SEQ_BITS-1:0]   window_base;
  logic [SLOT_BITS-1:0]  head;
  logic [WINDOW_MAX-1:0] slot_valid;

  logic                  in_accept;
  logic [SBITS_BITS-1:0] b_eff;
  logic [SEQ_BITS:0]     m;
  logic [SEQ_BITS:0]     n_wide;
  logic [SEQ_BITS-1:0]   mmask;
  logic [SEQ_BITS-1:0]   base_eff;
  logic [SEQ_BITS-1:0]   d;
  logic                  seq_ok;
  logic                  in_cur;
  logic                  in_prev;
  logic                  deliver;
  logic                  buffer;
  logic [SLOT_BITS-1:0]  slot_d;
  logic [CNT_BITS-1:0]   k;
  logic                  run;
  logic [WINDOW_MAX-1:0] clr;

  assign cfg_ready = 1'b1;
  assign full      = cmd_full;
  assign in_accept = push && !cmd_full;

  always_comb begin
    b_eff = (seq_bits == '0 || seq_bits > SBITS_BITS'(SEQ_BITS)) ? SBITS_BITS'(SEQ_BITS)
                                                                 : seq_bits;
    m        = (SEQ_BITS+1)'(1) << b_eff;
    mmask    = SEQ_BITS'(m - (SEQ_BITS+1)'(1));
    base_eff = window_base & mmask;
    if (32'(window_size) > WINDOW_MAX) n_wide = (SEQ_BITS+1)'(WINDOW_MAX);
    else                               n_wide = (SEQ_BITS+1)'(window_size);
    if (n_wide > m) n_wide = m;
    d       = (seq_num - base_eff) & mmask;
    seq_ok  = checksum_ok && ((seq_num & ~mmask) == '0) && (n_wide != '0);
    in_cur  = seq_ok && ({1'b0, d} < n_wide);
    in_prev = seq_ok && !in_cur && ({1'b0, d} >= m - n_wide);
    slot_d  = slot_add(head, CNT_BITS'(d));
    deliver = in_cur && (d == '0);
    buffer  = in_cur && (d != '0) && !slot_valid[slot_d];

    // base delivery plus the run of buffered successors
    k   = CNT_BITS'(1);
    run = 1'b1;
    for (int j = 1; j < WINDOW_MAX; j++) begin
      if (run && slot_valid[slot_add(head, CNT_BITS'(j))]) k = k + CNT_BITS'(1);
      else run = 1'b0;
    end

    // slots consumed by this delivery, by offset from head
    for (int i = 0; i < WINDOW_MAX; i++) begin
      clr[i] = (((i >= int'(head)) ? (i - int'(head)) : (i + WINDOW_MAX - int'(head)))
                < int'(k));
    end

    cmd.deliver = deliver;
    cmd.seq     = seq_num;
    cmd.mmask   = mmask;
    cmd.payload = payload;
    cmd.wr_slot = buffer;
    cmd.slot    = deliver ? slot_add(head, CNT_BITS'(1)) : slot_d;
    cmd.count   = k;
    cmd_push    = in_accept && (in_cur || in_prev);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_RESET;
      seq_bits    <= SBITS_RESET;
      window_base <= '0;
      head        <= '0;
      slot_valid  <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_WINDOW_SIZE: window_size <= cfg_data[WSIZE_BITS-1:0];
          REG_SEQ_BITS:    seq_bits    <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept) begin
        window_base <= deliver ? ((base_eff + SEQ_BITS'(k)) & mmask) : base_eff;
        if (deliver) begin
          head <= slot_add(head, k);
          for (int i = 0; i < WINDOW_MAX; i++) begin
            if (clr[i]) slot_valid[i] <= 1'b0;
          end
        end else if (buffer) begin
          slot_valid[slot_d] <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // the base slot is never held as buffered
  a_head_free: assert property (@(posedge clk) disable iff (rst) !slot_valid[head])
    else $error("slot at window base marked valid");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) cmd_push |-> !cmd_full)
    else $error("command queued while queue full");
  a_corrupt_silent: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !checksum_ok) |-> !cmd_push)
    else $error("corrupt packet produced a command");
`endif

endmodule

FILE: rtl/core/srr_cmd_fifo.sv
// srr_cmd_fifo: short command queue between classifier and sequencer.
// Depends on srr_pkg for the command type and depth.
module srr_cmd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  srr_pkg::srr_cmd_t wdata,
  input  logic              pop,
  output logic              empty,
  output srr_pkg::srr_cmd_t rdata
);
  import srr_pkg::*;

  srr_cmd_t                  entries [CMD_DEPTH];
  logic [CMD_PTR_BITS-1:0]   wr_ptr;
  logic [CMD_PTR_BITS-1:0]   rd_ptr;
  logic [CMD_CNT_BITS-1:0]   count;
  logic                      do_push;
  logic                      do_pop;

  assign full    = (count == CMD_CNT_BITS'(CMD_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CMD_PTR_BITS'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CMD_PTR_BITS'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wdata;
  end

endmodule

FILE: rtl/core/srr_back.sv
// srr_back: reorder payload store and result sequencer; emits the ack and
// then the in-order deliveries of each command. Depends on srr_pkg.
module srr_back (
  input  logic                             clk,
  input  logic                             rst,
  input  srr_pkg::srr_cmd_t                cmd,
  input  logic                             cmd_empty,
  output logic                             cmd_pop,
  output logic                             empty,
  input  logic                             pop,
  output logic                             kind,
  output logic [srr_pkg::SEQ_BITS-1:0]     ack_seq,
  output logic [srr_pkg::PAYLOAD_BITS-1:0] delivered_payload,
  output logic                             last
);
  import srr_pkg::*;

  logic [PAYLOAD_BITS-1:0] slot_mem [WINDOW_MAX];

  logic                    out_valid;
  logic                    busy;
  logic                    first;
  logic [CNT_BITS-1:0]     remaining;
  logic [SEQ_BITS-1:0]     cur_seq;
  logic [SEQ_BITS-1:0]     cur_mmask;
  logic [SLOT_BITS-1:0]    cur_slot;
  logic [PAYLOAD_BITS-1:0] first_payload;

  logic                    out_free;
  logic                    load_dlv;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign cmd_pop  = !busy && !cmd_empty && out_free;
  assign load_dlv = busy && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else begin
      if (cmd_pop) begin
        out_valid <= 1'b1;
        busy      <= cmd.deliver;
      end else if (load_dlv) begin
        out_valid <= 1'b1;
        busy      <= (remaining != CNT_BITS'(1));
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      kind              <= KIND_ACK;
      ack_seq           <= cmd.seq;
      delivered_payload <= '0;
      last              <= !cmd.deliver;
      remaining         <= cmd.count;
      cur_seq           <= cmd.seq;
      cur_mmask         <= cmd.mmask;
      cur_slot          <= cmd.slot;
      first             <= 1'b1;
      first_payload     <= cmd.payload;
      if (cmd.wr_slot) slot_mem[cmd.slot] <= cmd.payload;
    end else if (load_dlv) begin
      kind              <= KIND_DELIVER;
      ack_seq           <= cur_seq;
      delivered_payload <= first ? first_payload : slot_mem[cur_slot];
      last              <= (remaining == CNT_BITS'(1));
      remaining         <= remaining - CNT_BITS'(1);
      cur_seq           <= (cur_seq + 1'b1) & cur_mmask;
      first             <= 1'b0;
      // the packet's own payload goes first, then buffered slots
      if (!first) cur_slot <= slot_add(cur_slot, CNT_BITS'(1));
    end
  end

`ifndef SYNTHESIS
  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> (remaining != '0))
    else $error("sequencer busy with nothing left to deliver");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst) cmd_pop |-> !busy)
    else $error("command taken while deliveries pending");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid)
    else $error("waiting result dropped");
`endif

endmodule

FILE: rtl/core/selective_repeat_receiver.sv
// selective_repeat_receiver: top level of the selective-repeat ARQ receiver.
// Depends on srr_pkg, srr_front, srr_cmd_fifo and srr_back.
//
// Packets enter through a queue-style port: an item is taken at a clock edge
// with push high and full low. Results leave the same way: the oldest result
// sits on kind, ack_seq, delivered_payload and last while empty is low, and
// is taken on an edge with pop high. Each packet gives either nothing
// (corrupt, out of range or outside both windows), one ack, or an ack
// followed by the in-order deliveries it releases; last marks its final one.
// window_size and seq_bits are written over the cfg port (always ready) and
// should only change while no packet is in flight.
// The classifier takes one packet per cycle while full is low; a command queue
// of two entries sits in front of the sequencer. The first result passes
// through that queue and the output register. The sequencer puts out one
// result per cycle while pop is high: each packet's ack, then its deliveries.
// Synchronous reset sets window_size 4, seq_bits 3, base 0 and clears the
// valid marks at once. When pop stays low, results wait in the output
// register, the queue fills and full rises until the consumer drains it.
module selective_repeat_receiver (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [srr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [srr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               push,
  output logic                               full,
  input  logic [srr_pkg::SEQ_BITS-1:0]       seq_num,
  input  logic                               checksum_ok,
  input  logic [srr_pkg::PAYLOAD_BITS-1:0]   payload,
  output logic                               empty,
  input  logic                               pop,
  output logic                               kind,
  output logic [srr_pkg::SEQ_BITS-1:0]       ack_seq,
  output logic [srr_pkg::PAYLOAD_BITS-1:0]   delivered_payload,
  output logic                               last
);
  import srr_pkg::*;

  srr_cmd_t cmd_in;
  srr_cmd_t cmd_out;
  logic     cmd_push;
  logic     cmd_full;
  logic     cmd_pop;
  logic     cmd_empty;

  srr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .seq_num     (seq_num),
    .checksum_ok (checksum_ok),
    .payload     (payload),
    .cmd         (cmd_in),
    .cmd_push    (cmd_push),
    .cmd_full    (cmd_full)
  );

  srr_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .full  (cmd_full),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd_out)
  );

  srr_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd_out),
    .cmd_empty         (cmd_empty),
    .cmd_pop           (cmd_pop),
    .empty             (empty),
    .pop               (pop),
    .kind              (kind),
    .ack_seq           (ack_seq),
    .delivered_payload (delivered_payload),
    .last              (last)
  );

endmodule

FILE: dv/srr_checker.sv
// srr_checker: watches the register, packet and result channels of the
// selective-repeat receiver, predicts acks and in-order deliveries, compares.
// Depends on srr_pkg.
module srr_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [srr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [srr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               push,
  input  logic                               full,
  input  logic [srr_pkg::SEQ_BITS-1:0]       seq_num,
  input  logic                               checksum_ok,
  input  logic [srr_pkg::PAYLOAD_BITS-1:0]   payload,
  input  logic                               empty,
  input  logic                               pop,
  input  logic                               kind,
  input  logic [srr_pkg::SEQ_BITS-1:0]       ack_seq,
  input  logic [srr_pkg::PAYLOAD_BITS-1:0]   delivered_payload,
  input  logic                               last,
  output int                                 fail_count,
  output int                                 outstanding,
  output int                                 answered,
  output int                                 acks_checked,
  output int                                 deliveries_checked,
  output logic [srr_pkg::SEQ_BITS-1:0]       cur_base,
  output int                                 cur_span,
  output logic [srr_pkg::SEQ_BITS:0]         cur_space
);
  timeunit 1ns;
  timeprecision 1ps;
  import srr_pkg::*;

  typedef struct packed {
    logic                    kind;
    logic [SEQ_BITS-1:0]     seq;
    logic [PAYLOAD_BITS-1:0] data;
    logic                    last;
  } reply_t;

  reply_t                  owed_replies[$];
  logic [WSIZE_BITS-1:0]   win_reg = WSIZE_RESET;
  logic [SBITS_BITS-1:0]   seqw_reg = SBITS_RESET;
  logic [SEQ_BITS-1:0]     base = '0;
  logic                    slot_full [WINDOW_MAX];
  logic [PAYLOAD_BITS-1:0] slot_data [WINDOW_MAX];
  int fails = 0;
  int acks = 0;
  int dels = 0;
  int answered_n = 0;

  initial begin
    fail_count = 0;
    outstanding = 0;
    answered = 0;
    acks_checked = 0;
    deliveries_checked = 0;
    cur_base = '0;
    cur_span = 4;
    cur_space = 17'd8;
  end

  function automatic logic [SEQ_BITS:0] seq_space(input logic [SBITS_BITS-1:0] w);
    if (w == 0 || w > SEQ_BITS) return 17'h10000;
    return 17'd1 << w;
  endfunction

  function automatic int span_of(input logic [WSIZE_BITS-1:0] w,
                                 input logic [SEQ_BITS:0] space);
    int n;
    n = w;
    if (n > WINDOW_MAX) n = WINDOW_MAX;
    if (n > space) n = space;
    return n;
  endfunction

  // base moves on by one and the reorder store slides down with it
  function automatic void advance_base(input logic [SEQ_BITS-1:0] mmask);
    base = (base + 1'b1) & mmask;
    for (int i = 0; i < WINDOW_MAX - 1; i++) begin
      slot_full[i] = slot_full[i + 1];
      slot_data[i] = slot_data[i + 1];
    end
    slot_full[WINDOW_MAX - 1] = 1'b0;
    slot_data[WINDOW_MAX - 1] = '0;
  endfunction

  function automatic void receive_packet(input logic [SEQ_BITS-1:0] seq, input logic ok,
                                         input logic [PAYLOAD_BITS-1:0] pay);
    reply_t              batch [WINDOW_MAX + 1];
    reply_t              r;
    logic [SEQ_BITS:0]   space;
    logic [SEQ_BITS-1:0] mmask;
    logic [SEQ_BITS-1:0] gap;
    int                  span;
    int                  cnt;
    space = seq_space(seqw_reg);
    mmask = SEQ_BITS'(space - 1);
    span = span_of(win_reg, space);
    cnt = 0;
    base = base & mmask;
    if (!ok || {1'b0, seq} >= space || span == 0) return;
    gap = (seq - base) & mmask;
    if (gap < span) begin
      batch[cnt] = '{KIND_ACK, seq, '0, 1'b0};
      cnt++;
      if (gap == 0) begin
        batch[cnt] = '{KIND_DELIVER, seq, pay, 1'b0};
        cnt++;
        advance_base(mmask);
        while (slot_full[0] && cnt < WINDOW_MAX + 1) begin
          batch[cnt] = '{KIND_DELIVER, base, slot_data[0], 1'b0};
          cnt++;
          advance_base(mmask);
        end
      end else if (!slot_full[gap]) begin
        slot_full[gap] = 1'b1;
        slot_data[gap] = pay;
      end
    end else if (gap >= space - span) begin
      // previous window: re-ack only
      batch[cnt] = '{KIND_ACK, seq, '0, 1'b0};
      cnt++;
    end
    for (int i = 0; i < cnt; i++) begin
      r = batch[i];
      r.last = (i == cnt - 1);
      owed_replies.push_back(r);
    end
    if (cnt > 0) answered_n++;
  endfunction

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    logic [SEQ_BITS:0] space_now;
    reply_t            want;
    if (rst) begin
      win_reg = WSIZE_RESET;
      seqw_reg = SBITS_RESET;
      base = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
        slot_full[i] = 1'b0;
        slot_data[i] = '0;
      end
      owed_replies.delete();
    end else begin
      if (pop && !empty) begin
        if (owed_replies.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got kind %0d seq %0h data %0h last %0d",
                   $time, kind, ack_seq, delivered_payload, last);
        end else begin
          want = owed_replies.pop_front();
          check_field("kind", 64'(want.kind), 64'(kind));
          check_field("ack_seq", 64'(want.seq), 64'(ack_seq));
          check_field("delivered_payload", want.data, delivered_payload);
          check_field("last", 64'(want.last), 64'(last));
          if (want.kind == KIND_ACK) acks++;
          else dels++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW_SIZE) win_reg = cfg_data[WSIZE_BITS-1:0];
        else if (cfg_index == REG_SEQ_BITS) seqw_reg = cfg_data;
      end
      if (push && !full) receive_packet(seq_num, checksum_ok, payload);
    end
    space_now = seq_space(seqw_reg);
    fail_count <= fails;
    outstanding <= owed_replies.size();
    answered <= answered_n;
    acks_checked <= acks;
    deliveries_checked <= dels;
    cur_base <= base & SEQ_BITS'(space_now - 1);
    cur_span <= span_of(win_reg, space_now);
    cur_space <= space_now;
  end

endmodule

FILE: dv/selective_repeat_receiver_tb.sv
// selective_repeat_receiver_tb: drives packets and register writes into the
// selective-repeat receiver and pops its results; srr_checker does the checking.
// Depends on srr_pkg, selective_repeat_receiver and srr_checker.
module selective_repeat_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srr_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 80;
  localparam int CYCLE_LIMIT   = 400000;
  // index with no register behind it
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 4'd9;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      push = 1'b0;
  logic                      full;
  logic [SEQ_BITS-1:0]       seq_num = '0;
  logic                      checksum_ok = 1'b0;
  logic [PAYLOAD_BITS-1:0]   payload = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic                      kind;
  logic [SEQ_BITS-1:0]       ack_seq;
  logic [PAYLOAD_BITS-1:0]   delivered_payload;
  logic                      last;

  int                  fail_count;
  int                  outstanding;
  int                  answered;
  int                  acks_checked;
  int                  deliveries_checked;
  logic [SEQ_BITS-1:0] cur_base;
  int                  cur_span;
  logic [SEQ_BITS:0]   cur_space;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int packets_sent = 0;
  int settings_used = 0;
  int cycle_count = 0;

  selective_repeat_receiver u_dut (.*);

  srr_checker u_checker (.*);

  always #5 clk = ~clk;

  // consumer: random stalls, plus a long hold-off each time hold_token moves
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, outstanding);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [PAYLOAD_BITS-1:0] any_payload();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_packet(input logic [SEQ_BITS-1:0] s, input logic ok,
                             input logic [PAYLOAD_BITS-1:0] p);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    seq_num <= s;
    checksum_ok <= ok;
    payload <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    packets_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_BITS-1:0] ws,
                               input logic [CFG_DATA_BITS-1:0] sb);
    write_reg(REG_WINDOW_SIZE, ws);
    write_reg(REG_SEQ_BITS, sb);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // stop sending, wait for every owed result, then let the pipeline settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random();
    logic [SEQ_BITS-1:0] mask;
    int                  pick;
    mask = SEQ_BITS'(cur_space - 1);
    pick = $urandom_range(99);
    if (pick < 8)
      send_packet(SEQ_BITS'($urandom) & mask, 1'b0, any_payload());
    else if (pick < 14)
      send_packet(SEQ_BITS'($urandom), 1'b1, any_payload());
    else if (pick < 24)
      send_packet((cur_base - SEQ_BITS'(1 + $urandom_range(cur_span - 1))) & mask, 1'b1,
                  any_payload());
    else if (pick < 50)
      send_packet(cur_base, 1'b1, any_payload());
    else
      send_packet((cur_base + SEQ_BITS'($urandom_range(cur_span - 1))) & mask, 1'b1,
                  any_payload());
  endtask

  // fill the whole window from the top down, then the base releases it all
  task automatic send_burst();
    logic [SEQ_BITS-1:0] b;
    logic [SEQ_BITS-1:0] mask;
    int                  k;
    push <= 1'b0;
    @(posedge clk);
    b = cur_base;
    mask = SEQ_BITS'(cur_space - 1);
    k = cur_span;
    for (int off = k - 1; off >= 1; off--)
      send_packet((b + SEQ_BITS'(off)) & mask, 1'b1, any_payload());
    send_packet(b, 1'b1, any_payload());
  endtask

  task automatic run_phase(input logic [CFG_DATA_BITS-1:0] ws,
                           input logic [CFG_DATA_BITS-1:0] sb,
                           input int idle, input int stall, input int goal);
    int start;
    apply_setting(ws, sb);
    sender_idle_pct = idle;
    recv_stall_pct = stall;
    start = answered;
    while (answered - start < goal) begin
      if ($urandom_range(9) == 0) send_burst();
      else send_random();
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: window 4 over 8 sequence numbers, base 0
    send_packet(16'd0, 1'b1, '1);
    send_packet(16'd2, 1'b1, any_payload());
    send_packet(16'd3, 1'b1, any_payload());
    send_packet(16'd2, 1'b1, any_payload());   // duplicate keeps the first copy
    send_packet(16'd1, 1'b1, '0);              // releases 1, 2, 3
    send_packet(16'd5, 1'b0, any_payload());   // corrupt
    send_packet(16'd1, 1'b1, any_payload());   // previous window
    send_packet(16'd8, 1'b1, any_payload());   // beyond sequence space
    send_packet(16'hffff, 1'b1, any_payload());
    drain();

    // window written as 16 keeps only the low bits, so zero: nothing answered
    write_reg(REG_SPARE, 5'h1f);
    apply_setting(5'd16, 5'd3);
    send_packet(16'd4, 1'b1, any_payload());
    drain();

    // full window of 8 over 16: one in-order arrival drains eight
    apply_setting(5'd8, 5'd4);
    for (int s = 11; s >= 5; s--) send_packet(SEQ_BITS'(s), 1'b1, any_payload());
    send_packet(16'd4, 1'b1, any_payload());
    drain();

    // shrink the sequence space under a base of 12, then shrink the window
    // with entries still buffered beyond it
    apply_setting(5'd8, 5'd3);
    send_packet(16'd6, 1'b1, any_payload());
    send_packet(16'd7, 1'b1, any_payload());
    drain();
    apply_setting(5'd2, 5'd3);
    send_packet(16'd5, 1'b1, any_payload());
    send_packet(16'd4, 1'b1, any_payload());
    send_packet(16'd6, 1'b1, any_payload());
    drain();

    // sequence width zero means the full 16-bit space
    apply_setting(5'd1, 5'd0);
    send_packet(16'hffff, 1'b1, '1);
    send_packet(16'd0, 1'b1, any_payload());
    drain();

    run_phase(5'd4, 5'd3, 0, 0, 17);
    run_phase(5'd8, 5'd4, 88, 0, 16);
    run_phase(5'd1, 5'd1, 0, 88, 15);
    run_phase(5'd3, 5'd16, 35, 35, 16);
    run_phase(5'd15, 5'd1, 0, 0, 15);
    run_phase(5'd5, 5'd0, 88, 0, 15);
    run_phase(5'd2, 5'd31, 0, 88, 15);
    run_phase(5'd15, 5'd5, 35, 35, 16);
    run_phase(5'd7, 5'd2, 0, 0, 15);

    // consumer holds off while packets keep coming, so full has to rise
    apply_setting(5'd8, 5'd4);
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_token <= hold_token + 1;
    repeat (24) send_random();
    drain();

    run_phase(5'd6, 5'd3, 35, 35, 15);

    $display("sent %0d packets across %0d register settings, with idle, stall and hold-off phases",
             packets_sent, settings_used);
    $display("checked %0d acks and %0d in-order deliveries, %0d mismatches",
             acks_checked, deliveries_checked, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/srr_pkg.sv
rtl/core/srr_front.sv
rtl/core/srr_cmd_fifo.sv
rtl/core/srr_back.sv
rtl/core/selective_repeat_receiver.sv
dv/srr_checker.sv
dv/selective_repeat_receiver_tb.sv
